// ===== design/ssinv_pkg.sv =====
// -----------------------------------------------------------------------------
// ssinv_pkg
// Shared types and constants for the servo speed table inverse lookup unit.
// -----------------------------------------------------------------------------
package ssinv_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 21;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // field widths
   localparam int MODE_W      = 1;
   localparam int ENTRY_IDX_W = 5;
   localparam int SPEED_W     = 16;
   localparam int SSPEED_W    = 17;
   localparam int MAG_W       = 17;
   localparam int PULSE_W     = 12;
   localparam int STEP_W      = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 12;

   // arithmetic widths
   localparam int STEP_MAX   = (1 << STEP_W) - 1;
   localparam int OFF_W      = $clog2((TABLE_ENTRIES - 1) * STEP_MAX + 1);
   localparam int SUM_W      = ((PULSE_W > OFF_W) ? PULSE_W : OFF_W) + 2;
   localparam int DIVIDEND_W = STEP_W + MAG_W;
   localparam int DIVISOR_W  = SPEED_W;
   localparam int QUO_W      = STEP_W;
   localparam int QBIT_W     = (QUO_W > 1) ? $clog2(QUO_W) : 1;
   localparam int BASE_W     = IDX_W + STEP_W;

   localparam logic [PULSE_W-1:0] PULSE_MAX    = {PULSE_W{1'b1}};
   localparam logic [PULSE_W-1:0] CENTER_RESET = PULSE_W'(1500);
   localparam logic [STEP_W-1:0]  STEP_RESET   = STEP_W'(5);

   // codes
   localparam logic [MODE_W-1:0]    MODE_LOAD        = 1'b0;
   localparam logic [MODE_W-1:0]    MODE_CONVERT     = 1'b1;
   localparam logic                 WHEEL_LEFT       = 1'b0;
   localparam logic                 WHEEL_RIGHT      = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_PULSE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE    = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH,
      S_MUL,
      S_DIV,
      S_WEND,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== design/servo_speed_table_inverse_interp_unit.sv =====
// -----------------------------------------------------------------------------
// servo_speed_table_inverse_interp_unit
// Turns a signed wheel speed pair into two servo pulse widths by inverse
// lookup with linear interpolation in per-wheel calibration tables.
// -----------------------------------------------------------------------------
// A load beat writes one in-range calibration entry and gives no result.
// A convert beat scans the left table, then the right table, one entry per
// cycle on each table's single read port, and interpolates between the two
// entries around the speed with a 5-step serial divider. The result sits in an
// output register, so the next beat can be taken while it waits.
// Table entries are not cleared by reset and must be loaded before use.
// -----------------------------------------------------------------------------
module servo_speed_table_inverse_interp_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ssinv_pkg::MODE_W-1:0]        req_mode,
   input  logic                                req_wheel_side,
   input  logic [ssinv_pkg::ENTRY_IDX_W-1:0]   req_entry_index,
   input  logic [ssinv_pkg::SPEED_W-1:0]       req_entry_speed,
   input  logic signed [ssinv_pkg::SSPEED_W-1:0] req_left_speed,
   input  logic signed [ssinv_pkg::SSPEED_W-1:0] req_right_speed,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ssinv_pkg::PULSE_W-1:0]       rsp_left_pulse,
   output logic [ssinv_pkg::PULSE_W-1:0]       rsp_right_pulse,
   output logic                                rsp_left_saturated,
   output logic                                rsp_right_saturated,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssinv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssinv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssinv_pkg::*;

   state_type state_ff, state_in;

   logic [PULSE_W-1:0] center_ff, center_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 wheel_ff, wheel_in;
   logic [MAG_W-1:0]     lmag_ff, lmag_in, rmag_ff, rmag_in;
   logic                 lneg_ff, lneg_in, rneg_ff, rneg_in;
   logic [SPEED_W-1:0]   prev_ff, prev_in;
   logic [MAG_W-1:0]     diff_ff, diff_in;
   logic [SPEED_W-1:0]   den_ff, den_in;
   logic [OFF_W-1:0]     base_ff, base_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic                 sat_ff, sat_in;
   logic [PULSE_W-1:0]   lp_ff, lp_in, rp_ff, rp_in;
   logic                 lsat_ff, lsat_in, rsat_ff, rsat_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]   rsp_lp_ff, rsp_lp_in, rsp_rp_ff, rsp_rp_in;
   logic                 rsp_lsat_ff, rsp_lsat_in, rsp_rsat_ff, rsp_rsat_in;

   logic req_acc, csr_acc, is_convert, out_free;
   logic load_ok, wr_left, wr_right, rd_en_left, rd_en_right, rd_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [SPEED_W-1:0] rdata_left, rdata_right, rdata;
   logic [MAG_W-1:0] cur_mag, t_ext;
   logic cur_neg;
   logic [CNT_W-1:0] j_cnt;
   logic srch_chk, hit_eq, hit_gt, is_first, is_last;
   logic [MAG_W-1:0] lmag_new, rmag_new;
   logic do_add, pulse_sat;
   logic signed [SUM_W-1:0] cen_s, off_s, sum_s;
   logic [PULSE_W-1:0] pulse_val;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // handshakes
   assign req_stall  = (state_ff != S_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_acc    = csr_valid && csr_ready;
   assign is_convert = (req_mode == MODE_CONVERT);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // table writes
   assign load_ok  = req_acc && !is_convert &&
                     (32'(req_entry_index) < 32'(TABLE_ENTRIES));
   assign wr_addr  = IDX_W'(req_entry_index);
   assign wr_left  = load_ok && (req_wheel_side == WHEEL_LEFT);
   assign wr_right = load_ok && (req_wheel_side == WHEEL_RIGHT);

   // table scan reads, one entry a cycle
   assign rd_en       = (state_ff == S_SRCH) && (32'(cnt_ff) < 32'(TABLE_ENTRIES));
   assign rd_addr     = cnt_ff[IDX_W-1:0];
   assign rd_en_left  = rd_en && (wheel_ff == WHEEL_LEFT);
   assign rd_en_right = rd_en && (wheel_ff == WHEEL_RIGHT);

   ssinv_ram #(.WIDTH(SPEED_W), .DEPTH(TABLE_ENTRIES)) u_left_table (
      .clock   (clock),
      .wr_en   (wr_left),
      .wr_addr (wr_addr),
      .wr_data (req_entry_speed),
      .rd_en   (rd_en_left),
      .rd_addr (rd_addr),
      .rd_data (rdata_left)
   );

   ssinv_ram #(.WIDTH(SPEED_W), .DEPTH(TABLE_ENTRIES)) u_right_table (
      .clock   (clock),
      .wr_en   (wr_right),
      .wr_addr (wr_addr),
      .wr_data (req_entry_speed),
      .rd_en   (rd_en_right),
      .rd_addr (rd_addr),
      .rd_data (rdata_right)
   );

   ssinv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // magnitudes of the incoming speeds
   assign lmag_new = req_left_speed[SSPEED_W-1]  ? MAG_W'(~req_left_speed + 1'b1)
                                                 : MAG_W'(req_left_speed);
   assign rmag_new = req_right_speed[SSPEED_W-1] ? MAG_W'(~req_right_speed + 1'b1)
                                                 : MAG_W'(req_right_speed);

   // search decision; data returned this cycle belongs to entry cnt-1
   assign rdata    = (wheel_ff == WHEEL_RIGHT) ? rdata_right : rdata_left;
   assign cur_mag  = (wheel_ff == WHEEL_RIGHT) ? rmag_ff : lmag_ff;
   assign cur_neg  = (wheel_ff == WHEEL_RIGHT) ? rneg_ff : lneg_ff;
   assign t_ext    = MAG_W'(rdata);
   assign j_cnt    = cnt_ff - 1'b1;
   assign srch_chk = (state_ff == S_SRCH) && (cnt_ff != '0);
   assign hit_eq   = (t_ext == cur_mag);
   assign hit_gt   = (t_ext > cur_mag);
   assign is_first = (j_cnt == '0);
   assign is_last  = (32'(j_cnt) == 32'(TABLE_ENTRIES - 1));

   // signed offset applied to the center pulse; right side is mirrored
   assign do_add = (wheel_ff == WHEEL_LEFT) ^ cur_neg;
   assign cen_s  = signed'(SUM_W'(center_ff));
   assign off_s  = signed'(SUM_W'(off_ff));
   assign sum_s  = do_add ? (cen_s + off_s) : (cen_s - off_s);

   always_comb begin
      pulse_sat = 1'b0;
      pulse_val = sum_s[PULSE_W-1:0];
      if (sum_s < 0) begin
         pulse_sat = 1'b1;
         pulse_val = '0;
      end else if (sum_s > signed'(SUM_W'(PULSE_MAX))) begin
         pulse_sat = 1'b1;
         pulse_val = PULSE_MAX;
      end
   end

   // divider request: step times distance above the lower entry
   always_comb begin
      div_req.start    = (state_ff == S_MUL);
      div_req.dividend = DIVIDEND_W'(step_ff) * DIVIDEND_W'(diff_ff);
      div_req.divisor  = den_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && is_convert) begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (srch_chk) begin
               if (hit_eq || (hit_gt && is_first) || (!hit_gt && is_last)) begin
                  state_in = S_WEND;
               end else if (hit_gt) begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_WEND;
            end
         end
         S_WEND: begin
            state_in = (wheel_ff == WHEEL_LEFT) ? S_SRCH : S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      center_in   = center_ff;
      step_in     = step_ff;
      cnt_in      = cnt_ff;
      wheel_in    = wheel_ff;
      lmag_in     = lmag_ff;
      rmag_in     = rmag_ff;
      lneg_in     = lneg_ff;
      rneg_in     = rneg_ff;
      prev_in     = prev_ff;
      diff_in     = diff_ff;
      den_in      = den_ff;
      base_in     = base_ff;
      off_in      = off_ff;
      sat_in      = sat_ff;
      lp_in       = lp_ff;
      rp_in       = rp_ff;
      lsat_in     = lsat_ff;
      rsat_in     = rsat_ff;
      rsp_lp_in   = rsp_lp_ff;
      rsp_rp_in   = rsp_rp_ff;
      rsp_lsat_in = rsp_lsat_ff;
      rsp_rsat_in = rsp_rsat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_acc) begin
         unique case (csr_index)
            CSR_CENTER_PULSE: center_in = PULSE_W'(csr_wdata);
            CSR_STEP_SIZE:    step_in   = csr_wdata[STEP_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            cnt_in   = '0;
            wheel_in = WHEEL_LEFT;
            if (req_acc && is_convert) begin
               lmag_in = lmag_new;
               rmag_in = rmag_new;
               lneg_in = req_left_speed[SSPEED_W-1];
               rneg_in = req_right_speed[SSPEED_W-1];
            end
         end
         S_SRCH: begin
            cnt_in = cnt_ff + 1'b1;
            if (srch_chk) begin
               if (hit_eq) begin
                  off_in = OFF_W'(BASE_W'(j_cnt[IDX_W-1:0]) * step_ff);
                  sat_in = 1'b0;
               end else if (hit_gt) begin
                  off_in  = '0;
                  sat_in  = 1'b0;
                  diff_in = cur_mag - MAG_W'(prev_ff);
                  den_in  = rdata - prev_ff;
                  base_in = OFF_W'(BASE_W'(j_cnt[IDX_W-1:0] - 1'b1) * step_ff);
               end else begin
                  prev_in = rdata;
                  if (is_last) begin
                     // beyond the table: top step and flag
                     off_in = OFF_W'(BASE_W'(TABLE_ENTRIES - 1) * step_ff);
                     sat_in = 1'b1;
                  end
               end
            end
         end
         S_MUL: begin
         end
         S_DIV: begin
            if (div_rsp.done) begin
               off_in = base_ff + OFF_W'(div_rsp.quotient);
            end
         end
         S_WEND: begin
            cnt_in   = '0;
            wheel_in = WHEEL_RIGHT;
            if (wheel_ff == WHEEL_LEFT) begin
               lp_in   = pulse_val;
               lsat_in = sat_ff || pulse_sat;
            end else begin
               rp_in   = pulse_val;
               rsat_in = sat_ff || pulse_sat;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lp_in    = lp_ff;
               rsp_rp_in    = rp_ff;
               rsp_lsat_in  = lsat_ff;
               rsp_rsat_in  = rsat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         center_ff    <= CENTER_RESET;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         wheel_ff     <= WHEEL_LEFT;
      end else begin
         state_ff     <= state_in;
         center_ff    <= center_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         wheel_ff     <= wheel_in;
      end
      lmag_ff     <= lmag_in;
      rmag_ff     <= rmag_in;
      lneg_ff     <= lneg_in;
      rneg_ff     <= rneg_in;
      prev_ff     <= prev_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      base_ff     <= base_in;
      off_ff      <= off_in;
      sat_ff      <= sat_in;
      lp_ff       <= lp_in;
      rp_ff       <= rp_in;
      lsat_ff     <= lsat_in;
      rsat_ff     <= rsat_in;
      rsp_lp_ff   <= rsp_lp_in;
      rsp_rp_ff   <= rsp_rp_in;
      rsp_lsat_ff <= rsp_lsat_in;
      rsp_rsat_ff <= rsp_rsat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_pulse      = rsp_lp_ff;
   assign rsp_right_pulse     = rsp_rp_ff;
   assign rsp_left_saturated  = rsp_lsat_ff;
   assign rsp_right_saturated = rsp_rsat_ff;

endmodule

// ===== design/ssinv_ram.sv =====
// -----------------------------------------------------------------------------
// ssinv_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module ssinv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ssinv_div.sv =====
// -----------------------------------------------------------------------------
// ssinv_div
// Restoring divider, one quotient bit per cycle, for the interpolation
// fraction. The quotient is known to fit in QUO_W bits.
// -----------------------------------------------------------------------------
module ssinv_div (
   input  logic                   clock,
   input  logic                   reset,
   input  ssinv_pkg::div_req_type div_req,
   output ssinv_pkg::div_rsp_type div_rsp
);
   import ssinv_pkg::*;

   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [QBIT_W-1:0]     bit_ff, bit_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] trial;

   assign trial = DIVIDEND_W'(den_ff) << bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         den_in  = div_req.divisor;
         quo_in  = '0;
         bit_in  = QBIT_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in         = rem_ff - trial;
            quo_in[bit_ff] = 1'b1;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
